[rtl/ils_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_pkg
// Shared constants, operation and status codes, and the control bundle that
// the list controller broadcasts to every entry cell.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int DEPTH   = 16;
    localparam int WIDTH   = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int POS_IN_W = 5;
    localparam int PW      = (CNT_W > POS_IN_W) ? CNT_W : POS_IN_W;
    localparam int OP_W    = 3;
    localparam int ST_W    = 2;
    localparam int VAL_IN_W = 32;
    localparam int MPOS_W  = 4;

    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT     = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE     = 3'd3;
    localparam logic [OP_W-1:0] OP_ROT_LEFT   = 3'd4;
    localparam logic [OP_W-1:0] OP_ROT_RIGHT  = 3'd5;
    localparam logic [OP_W-1:0] OP_FIND       = 3'd6;
    localparam logic [OP_W-1:0] OP_READ       = 3'd7;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_OOB  = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic             fire;
        logic             ok;
        logic [OP_W-1:0]  op;
        logic [PW-1:0]    pos;
        logic [PW-1:0]    count;
        logic [WIDTH-1:0] value;
    } t_cell_ctrl;

endpackage

[rtl/ils_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_cell
// One list entry. Loads the new value, takes a neighbor's entry (or the head
// or tail entry) on a shift or rotate, and reports its compare, read and tail contributions.
// ----------------------------------------------------------------------------
module ils_cell (
    input  logic                      i_clk,
    input  logic [ils_pkg::PW-1:0]    i_index,
    input  ils_pkg::t_cell_ctrl       i_ctrl,
    input  logic [ils_pkg::WIDTH-1:0] i_left,
    input  logic [ils_pkg::WIDTH-1:0] i_right,
    input  logic [ils_pkg::WIDTH-1:0] i_head,
    input  logic [ils_pkg::WIDTH-1:0] i_tail,
    output logic [ils_pkg::WIDTH-1:0] o_entry,
    output logic                      o_match,
    output logic [ils_pkg::WIDTH-1:0] o_read,
    output logic [ils_pkg::WIDTH-1:0] o_tail
);

    logic [ils_pkg::WIDTH-1:0] r_entry;
    logic [ils_pkg::WIDTH-1:0] n_entry;
    logic [ils_pkg::PW-1:0]    idx_p1;
    logic                      live;
    logic                      multi;

    assign idx_p1 = i_index + ils_pkg::PW'(1);
    assign live   = i_index < i_ctrl.count;
    assign multi  = i_ctrl.count > ils_pkg::PW'(1);

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.fire) begin
            unique case (i_ctrl.op)
                ils_pkg::OP_PUSH_BACK: begin
                    if (i_ctrl.ok && i_index == i_ctrl.count) n_entry = i_ctrl.value;
                end
                ils_pkg::OP_PUSH_FRONT, ils_pkg::OP_INSERT: begin
                    if (i_ctrl.ok) begin
                        if (i_index == i_ctrl.pos) begin
                            n_entry = i_ctrl.value;
                        end else if (i_index > i_ctrl.pos && i_index <= i_ctrl.count) begin
                            n_entry = i_left;
                        end
                    end
                end
                ils_pkg::OP_DELETE: begin
                    if (i_ctrl.ok && i_index >= i_ctrl.pos && idx_p1 < i_ctrl.count) begin
                        n_entry = i_right;
                    end
                end
                ils_pkg::OP_ROT_LEFT: begin
                    if (multi) begin
                        if (idx_p1 < i_ctrl.count) begin
                            n_entry = i_right;
                        end else if (idx_p1 == i_ctrl.count) begin
                            n_entry = i_head;
                        end
                    end
                end
                ils_pkg::OP_ROT_RIGHT: begin
                    if (multi) begin
                        if (i_index == '0) begin
                            n_entry = i_tail;
                        end else if (live) begin
                            n_entry = i_left;
                        end
                    end
                end
                default: begin
                    n_entry = r_entry;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_match = live && (r_entry == i_ctrl.value);
    assign o_read  = (i_index == i_ctrl.pos) ? r_entry : '0;
    assign o_tail  = (idx_p1 == i_ctrl.count) ? r_entry : '0;

endmodule

[rtl/indexed_list_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list of entries held in a row of cells with a valid count.
// Each accepted request writes its result into the output register.
// Throughput: one request per cycle when the output is not stalled; the cell
// row shifts, compares and selects all entries in the same cycle.
// Reset clears the count and the output valid; entries are undefined until
// written, and only entries below the count are ever read.
// ----------------------------------------------------------------------------
module indexed_list_store (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_operation,
    input  logic [4:0]  i_position_in,
    input  logic [31:0] i_entry_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic        o_match_found,
    output logic [3:0]  o_match_position,
    output logic [31:0] o_read_value,
    output logic [4:0]  o_entry_count
);

    localparam int D = ils_pkg::DEPTH;

    logic                           accept;
    logic [ils_pkg::PW-1:0]         pos;
    logic [ils_pkg::PW-1:0]         cnt;
    logic [ils_pkg::ST_W-1:0]       status;
    ils_pkg::t_cell_ctrl            ctrl;
    logic [ils_pkg::WIDTH-1:0]      entry [D];
    logic [ils_pkg::WIDTH-1:0]      rd_part [D];
    logic [ils_pkg::WIDTH-1:0]      tl_part [D];
    logic [D-1:0]                   match;
    logic [ils_pkg::WIDTH-1:0]      rd_bus;
    logic [ils_pkg::WIDTH-1:0]      tl_bus;
    logic                           found;
    logic [ils_pkg::MPOS_W-1:0]     mpos;

    logic                           r_out_valid;
    logic [ils_pkg::CNT_W-1:0]      r_count;
    logic [ils_pkg::CNT_W-1:0]      n_count;
    logic [ils_pkg::ST_W-1:0]       r_status;
    logic                           r_found;
    logic [ils_pkg::MPOS_W-1:0]     r_mpos;
    logic [ils_pkg::VAL_IN_W-1:0]   r_rval;
    logic [ils_pkg::CNT_W-1:0]      r_out_count;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign cnt = ils_pkg::PW'(r_count);
    assign pos = (i_operation == ils_pkg::OP_PUSH_FRONT) ? '0 : ils_pkg::PW'(i_position_in);

    always_comb begin
        status = ils_pkg::ST_OK;
        unique case (i_operation)
            ils_pkg::OP_PUSH_BACK: begin
                if (cnt >= ils_pkg::PW'(D)) status = ils_pkg::ST_FULL;
            end
            ils_pkg::OP_PUSH_FRONT, ils_pkg::OP_INSERT: begin
                if (pos > cnt) begin
                    status = ils_pkg::ST_OOB;
                end else if (cnt >= ils_pkg::PW'(D)) begin
                    status = ils_pkg::ST_FULL;
                end
            end
            ils_pkg::OP_DELETE, ils_pkg::OP_READ: begin
                if (pos >= cnt) status = ils_pkg::ST_OOB;
            end
            default: begin
                status = ils_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        ctrl.fire  = accept;
        ctrl.ok    = (status == ils_pkg::ST_OK);
        ctrl.op    = i_operation;
        ctrl.pos   = pos;
        ctrl.count = cnt;
        ctrl.value = ils_pkg::WIDTH'(i_entry_value);
    end

    for (genvar g = 0; g < D; g++) begin : g_cell
        ils_cell u_cell (
            .i_clk   (i_clk),
            .i_index (ils_pkg::PW'(g)),
            .i_ctrl  (ctrl),
            .i_left  ((g == 0) ? '0 : entry[(g == 0) ? 0 : g - 1]),
            .i_right ((g == D - 1) ? '0 : entry[(g == D - 1) ? g : g + 1]),
            .i_head  (entry[0]),
            .i_tail  (tl_bus),
            .o_entry (entry[g]),
            .o_match (match[g]),
            .o_read  (rd_part[g]),
            .o_tail  (tl_part[g])
        );
    end

    always_comb begin
        rd_bus = '0;
        tl_bus = '0;
        for (int k = 0; k < D; k++) begin
            rd_bus = rd_bus | rd_part[k];
            tl_bus = tl_bus | tl_part[k];
        end
    end

    always_comb begin
        found = 1'b0;
        mpos  = '0;
        for (int k = D - 1; k >= 0; k--) begin
            if (match[k]) begin
                found = 1'b1;
                mpos  = ils_pkg::MPOS_W'(k);
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (status == ils_pkg::ST_OK) begin
            unique case (i_operation)
                ils_pkg::OP_PUSH_BACK, ils_pkg::OP_PUSH_FRONT, ils_pkg::OP_INSERT: begin
                    n_count = r_count + ils_pkg::CNT_W'(1);
                end
                ils_pkg::OP_DELETE: begin
                    n_count = r_count - ils_pkg::CNT_W'(1);
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (accept) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= status;
            r_found     <= (i_operation == ils_pkg::OP_FIND) && found;
            r_mpos      <= (i_operation == ils_pkg::OP_FIND && found) ? mpos : '0;
            r_rval      <= (i_operation == ils_pkg::OP_READ && status == ils_pkg::ST_OK)
                           ? ils_pkg::VAL_IN_W'(rd_bus) : '0;
            r_out_count <= n_count;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_match_found    = r_found;
    assign o_match_position = r_mpos;
    assign o_read_value     = r_rval;
    assign o_entry_count    = r_out_count;

endmodule

[rtl/ils_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_checker
// Port-level checks on the list store results, bound to the top level.
// ----------------------------------------------------------------------------
module ils_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic        o_match_found,
    input logic [3:0]  o_match_position,
    input logic [31:0] o_read_value,
    input logic [4:0]  o_entry_count
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_read_value) && $stable(o_entry_count))
        else $error("stalled result changed");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_entry_count <= 5'(ils_pkg::DEPTH))
        else $error("entry count above capacity");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ils_pkg::ST_FULL |-> o_entry_count == 5'(ils_pkg::DEPTH))
        else $error("full reported below capacity");

    a_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_match_found |-> o_status == ils_pkg::ST_OK
            && 5'(o_match_position) < o_entry_count)
        else $error("match outside the list");

endmodule

bind indexed_list_store ils_checker u_ils_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_status         (o_status),
    .o_match_found    (o_match_found),
    .o_match_position (o_match_position),
    .o_read_value     (o_read_value),
    .o_entry_count    (o_entry_count)
);
